// ===== rtl/core/mlfc_pkg.sv =====
// Shared types, constants and codes for the motor link frame codec.
package mlfc_pkg;

  // Default depth of the job queue between the front and back parts.
  localparam int unsigned QueueDepth = 4;

  // Frame bytes and positions.
  localparam logic [7:0] SyncByte    = 8'hA5;
  localparam logic [7:0] FuncDrive   = 8'h01;
  localparam logic [7:0] FuncSpeed   = 8'h02;
  localparam logic [7:0] SpeedReqSum = 8'hA7;
  localparam logic [2:0] FirstIdx    = 3'd0;
  localparam logic [2:0] LastIdx     = 3'd6;

  // Command codes of an input item.
  localparam logic [1:0] CmdDrive  = 2'd0;
  localparam logic [1:0] CmdSpeed  = 2'd1;
  localparam logic [1:0] CmdRx     = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  // Receive event codes.
  localparam logic [1:0] EvStored  = 2'd0;
  localparam logic [1:0] EvSpeed   = 2'd1;
  localparam logic [1:0] EvDropped = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [1:0]  RegDeadLeft     = 2'd0;
  localparam logic [1:0]  RegDeadRight    = 2'd1;
  localparam logic [1:0]  RegDriveLimit   = 2'd2;
  localparam logic [14:0] DriveLimitReset = 15'd10000;

  typedef enum logic {
    JOB_TX,
    JOB_RX
  } job_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
    logic [7:0]         rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic               last;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
    logic [1:0]         rx_event;
  } out_item_t;

  // A queued job: for a transmit job the six bytes after the sync byte,
  // for a receive job the received byte in the first slot.
  typedef struct packed {
    job_e            kind;
    logic [5:0][7:0] bytes;
  } job_t;

  typedef struct packed {
    logic [14:0] dead_left;
    logic [14:0] dead_right;
    logic [14:0] drive_limit;
  } cfg_t;

endpackage

// ===== rtl/core/mlfc_front.sv =====
// Front part: accepts items, scales and compensates drive values, builds jobs.
module mlfc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlfc_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mlfc_pkg::in_item_t in_item_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output mlfc_pkg::job_t     push_data_o
);
  import mlfc_pkg::*;

  // Add the dead-band to a nonzero magnitude, then saturate to the limit.
  function automatic logic [15:0] compensate(logic signed [17:0] v, logic [14:0] dead,
                                             logic [14:0] lim);
    logic signed [17:0] d;
    logic signed [17:0] l;
    logic signed [17:0] w;
    d = {3'b000, dead};
    l = {3'b000, lim};
    if (v > 0) begin
      w = v + d;
    end else if (v < 0) begin
      w = v - d;
    end else begin
      w = v;
    end
    if (w > l) begin
      w = l;
    end else if (w < -l) begin
      w = -l;
    end
    return w[15:0];
  endfunction

  logic               a_valid_q, a_valid_d;
  logic [1:0]         a_cmd_q;
  logic signed [17:0] a_left_q;
  logic signed [17:0] a_right_q;
  logic [7:0]         a_byte_q;

  logic               b_valid_q, b_valid_d;
  logic [1:0]         b_cmd_q;
  logic [15:0]        b_left_q;
  logic [15:0]        b_right_q;
  logic [7:0]         b_byte_q;

  logic               b_push;
  logic               advance;
  logic signed [17:0] left_ext;
  logic signed [17:0] right_ext;
  logic signed [17:0] right_x3;
  logic signed [17:0] right_adj;
  logic signed [17:0] right_half;
  logic [7:0]         check_sum;

  // Both stages move together whenever the last stage can hand off its job.
  assign b_push     = b_valid_q && (b_cmd_q != CmdUnused);
  assign advance    = !b_push || push_ready_i;
  assign in_ready_o = advance;

  // Right side times 3/2, truncated toward zero.
  assign left_ext   = {{2{in_item_i.drive_left[15]}}, in_item_i.drive_left};
  assign right_ext  = {{2{in_item_i.drive_right[15]}}, in_item_i.drive_right};
  assign right_x3   = (right_ext <<< 1) + right_ext;
  assign right_adj  = right_x3 + {17'd0, right_x3[17]};
  assign right_half = right_adj >>> 1;

  assign a_valid_d = advance ? in_valid_i : a_valid_q;
  assign b_valid_d = advance ? a_valid_q : b_valid_q;

  // Control registers of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      a_cmd_q   <= in_item_i.cmd;
      a_left_q  <= left_ext;
      a_right_q <= right_half;
      a_byte_q  <= in_item_i.rx_byte;
    end
    if (advance && a_valid_q) begin
      b_cmd_q   <= a_cmd_q;
      b_left_q  <= compensate(a_left_q, cfg_i.dead_left, cfg_i.drive_limit);
      b_right_q <= compensate(a_right_q, cfg_i.dead_right, cfg_i.drive_limit);
      b_byte_q  <= a_byte_q;
    end
  end

  assign check_sum = SyncByte + FuncDrive + b_right_q[15:8] + b_right_q[7:0]
                   + b_left_q[15:8] + b_left_q[7:0];

  // Build the job for the queue.
  always_comb begin
    push_data_o.kind  = JOB_TX;
    push_data_o.bytes = '0;
    unique case (b_cmd_q)
      CmdDrive: begin
        push_data_o.bytes = {check_sum, b_left_q[7:0], b_left_q[15:8],
                             b_right_q[7:0], b_right_q[15:8], FuncDrive};
      end
      CmdSpeed: begin
        push_data_o.bytes = {SpeedReqSum, 8'h00, 8'h00, 8'h00, 8'h00, FuncSpeed};
      end
      CmdRx: begin
        push_data_o.kind     = JOB_RX;
        push_data_o.bytes[0] = b_byte_q;
      end
      default: begin
        push_data_o.kind = JOB_TX;
      end
    endcase
  end

  assign push_valid_o = b_push;

endmodule

// ===== rtl/core/mlfc_queue.sv =====
// Short job queue between the front and back parts.
module mlfc_queue #(
  parameter int unsigned Depth = mlfc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mlfc_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output mlfc_pkg::job_t pop_data_o
);
  import mlfc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_ready_i && pop_valid_o;
  assign pop_data_o   = entries_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/mlfc_back.sv =====
// Back part: sends frame bytes, runs the receive machine, holds the output register.
module mlfc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  mlfc_pkg::job_t      pop_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlfc_pkg::out_item_t out_item_o
);
  import mlfc_pkg::*;

  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;
  logic [2:0]      tx_idx_q, tx_idx_d;
  logic [6:0][7:0] rx_frame_q, rx_frame_d;
  logic [2:0]      rx_count_q, rx_count_d;
  logic [15:0]     speed_left_q, speed_left_d;
  logic [15:0]     speed_right_q, speed_right_d;

  logic            load;
  logic            tx_last;
  logic [7:0]      tx_byte;
  logic [7:0]      rx_byte;
  logic [2:0]      rx_pos;
  logic            rx_complete;
  logic [7:0]      rx_sum;
  logic            rx_good;

  // A new result is loaded whenever a job is waiting and the output register is free or being taken.
  assign load    = pop_valid_i && (!out_valid_q || out_ready_i);
  assign tx_last = (tx_idx_q == LastIdx);

  // Byte of the current frame position.
  always_comb begin
    unique case (tx_idx_q)
      3'd0:    tx_byte = SyncByte;
      3'd1:    tx_byte = pop_data_i.bytes[0];
      3'd2:    tx_byte = pop_data_i.bytes[1];
      3'd3:    tx_byte = pop_data_i.bytes[2];
      3'd4:    tx_byte = pop_data_i.bytes[3];
      3'd5:    tx_byte = pop_data_i.bytes[4];
      default: tx_byte = pop_data_i.bytes[5];
    endcase
  end

  // Receive resync and frame check; a sync byte restarts an unsynced frame.
  assign rx_byte     = pop_data_i.bytes[0];
  assign rx_pos      = (rx_byte == SyncByte && rx_frame_q[0] != SyncByte) ? FirstIdx
                                                                          : rx_count_q;
  assign rx_complete = (rx_pos == LastIdx);
  assign rx_sum      = rx_frame_q[0] + rx_frame_q[1] + rx_frame_q[2] + rx_frame_q[3]
                     + rx_frame_q[4] + rx_frame_q[5];
  assign rx_good     = (rx_frame_q[0] == SyncByte) && (rx_frame_q[1] == FuncSpeed)
                     && (rx_sum == rx_byte);

  // Next state and next result.
  always_comb begin
    out_valid_d   = out_valid_q;
    out_item_d    = out_item_q;
    tx_idx_d      = tx_idx_q;
    rx_frame_d    = rx_frame_q;
    rx_count_d    = rx_count_q;
    speed_left_d  = speed_left_q;
    speed_right_d = speed_right_q;
    pop_ready_o   = 1'b0;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      unique case (pop_data_i.kind)
        JOB_TX: begin
          pop_ready_o = tx_last;
          tx_idx_d    = tx_last ? FirstIdx : tx_idx_q + 1'b1;
          out_item_d.tx_valid = 1'b1;
          out_item_d.tx_byte  = tx_byte;
          out_item_d.last     = tx_last;
          out_item_d.rx_event = EvStored;
        end
        JOB_RX: begin
          pop_ready_o = 1'b1;
          out_item_d.rx_event = EvStored;
          if (rx_complete) begin
            rx_frame_d = '0;
            rx_count_d = FirstIdx;
            if (rx_good) begin
              speed_right_d = {rx_frame_q[2], rx_frame_q[3]};
              speed_left_d  = {rx_frame_q[4], rx_frame_q[5]};
              out_item_d.rx_event = EvSpeed;
            end else begin
              out_item_d.rx_event = EvDropped;
            end
          end else begin
            rx_frame_d[rx_pos] = rx_byte;
            rx_count_d         = rx_pos + 1'b1;
          end
          out_item_d.tx_valid = 1'b0;
          out_item_d.tx_byte  = 8'h00;
          out_item_d.last     = 1'b1;
        end
        default: begin
          pop_ready_o = 1'b1;
        end
      endcase
      out_item_d.speed_left  = speed_left_d;
      out_item_d.speed_right = speed_right_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      tx_idx_q      <= FirstIdx;
      rx_frame_q    <= '0;
      rx_count_q    <= FirstIdx;
      speed_left_q  <= '0;
      speed_right_q <= '0;
    end else begin
      out_valid_q   <= out_valid_d;
      tx_idx_q      <= tx_idx_d;
      rx_frame_q    <= rx_frame_d;
      rx_count_q    <= rx_count_d;
      speed_left_q  <= speed_left_d;
      speed_right_q <= speed_right_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/motor_link_frame_codec.sv =====
// Top level of the motor link frame codec with its configuration registers.
// A set-drive or speed-request item produces seven frame bytes on the output
// channel, one per cycle unless the output stalls, and its job holds the head
// of the queue until the last byte; a received-byte item produces one result
// and sustains one per cycle unless the output stalls. The rate is set by the
// back part, which sends one frame byte per cycle from the head of the job
// queue. An accepted item passes two front stages and the queue. The front
// keeps accepting items until the queue of QueueDepth jobs fills, so a stalled
// output does not stall the input at once. Configuration registers sit at byte
// addresses 0 (left dead-band), 4 (right dead-band) and 8 (drive limit).
module motor_link_frame_codec #(
  parameter int unsigned QueueDepth = mlfc_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlfc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlfc_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mlfc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       cfg_write;
  logic [1:0] reg_idx;
  logic       push_valid;
  logic       push_ready;
  job_t       push_data;
  logic       pop_valid;
  logic       pop_ready;
  job_t       pop_data;

  // Configuration register writes.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (reg_idx)
        RegDeadLeft:   cfg_d.dead_left   = pwdata[14:0];
        RegDeadRight:  cfg_d.dead_right  = pwdata[14:0];
        RegDriveLimit: cfg_d.drive_limit = pwdata[14:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_left   <= '0;
      cfg_q.dead_right  <= '0;
      cfg_q.drive_limit <= DriveLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      RegDeadLeft:   prdata = {17'd0, cfg_q.dead_left};
      RegDeadRight:  prdata = {17'd0, cfg_q.dead_right};
      RegDriveLimit: prdata = {17'd0, cfg_q.drive_limit};
      default:       prdata = '0;
    endcase
  end

  mlfc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mlfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mlfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/sv/tb_motor_link_frame_codec.sv =====
// Self-checking testbench for the motor link frame codec: directed and random items.
`timescale 1ns / 1ps

module tb_motor_link_frame_codec;
  import mlfc_pkg::*;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_SUM,
    FRM_BAD_FUNC,
    FRM_BAD_HEAD,
    FRM_SHORT
  } frame_kind_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the configuration and of the receive machine.
  int          cfg_dead_l = 0;
  int          cfg_dead_r = 0;
  int          cfg_limit = int'(DriveLimitReset);
  logic [7:0]  rx_buf [7];
  int          rx_fill = 0;
  logic [15:0] spd_l = '0;
  logic [15:0] spd_r = '0;

  out_item_t   expected_out_q [$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  bit          no_idle = 1'b0;
  int          rdy_hold = 0;

  motor_link_frame_codec dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (rx_buf[k]) rx_buf[k] = 8'h00;
  end

  // Dead-band compensation followed by symmetric saturation.
  function automatic int comp_drive(int v, int dead, int lim);
    int w;
    w = v;
    if (w > 0) w = w + dead;
    else if (w < 0) w = w - dead;
    if (w > lim) return lim;
    if (w < -lim) return -lim;
    return w;
  endfunction

  // Queue the seven transmit results of one outgoing frame.
  function automatic void push_tx_frame(logic [6:0][7:0] frm);
    out_item_t r;
    for (int k = 0; k < 7; k++) begin
      r.tx_valid    = 1'b1;
      r.tx_byte     = frm[k];
      r.last        = (k == 6);
      r.speed_left  = spd_l;
      r.speed_right = spd_r;
      r.rx_event    = EvStored;
      expected_out_q.push_back(r);
    end
  endfunction

  // Work out the results that one accepted item causes.
  function automatic void predict(in_item_t it);
    logic [6:0][7:0] frm;
    out_item_t       r;
    int              lv;
    int              rv;
    logic [15:0]     ul;
    logic [15:0]     ur;
    logic [7:0]      sum;
    logic [1:0]      ev;
    frm = '0;
    case (it.cmd)
      CmdDrive: begin
        lv = $signed(it.drive_left);
        rv = $signed(it.drive_right);
        rv = (rv * 3) / 2;
        lv = comp_drive(lv, cfg_dead_l, cfg_limit);
        rv = comp_drive(rv, cfg_dead_r, cfg_limit);
        ul = 16'(lv);
        ur = 16'(rv);
        frm[0] = SyncByte;
        frm[1] = FuncDrive;
        frm[2] = ur[15:8];
        frm[3] = ur[7:0];
        frm[4] = ul[15:8];
        frm[5] = ul[7:0];
        sum = '0;
        for (int k = 0; k < 6; k++) sum = sum + frm[k];
        frm[6] = sum;
        push_tx_frame(frm);
      end
      CmdSpeed: begin
        frm[0] = SyncByte;
        frm[1] = FuncSpeed;
        frm[6] = SpeedReqSum;
        push_tx_frame(frm);
      end
      CmdRx: begin
        ev = EvStored;
        if (it.rx_byte == SyncByte && rx_buf[0] != SyncByte) rx_fill = 0;
        rx_buf[rx_fill] = it.rx_byte;
        rx_fill++;
        if (rx_fill == 7) begin
          sum = '0;
          for (int k = 0; k < 6; k++) sum = sum + rx_buf[k];
          if (rx_buf[0] == SyncByte && sum == rx_buf[6] && rx_buf[1] == FuncSpeed) begin
            spd_r = {rx_buf[2], rx_buf[3]};
            spd_l = {rx_buf[4], rx_buf[5]};
            ev = EvSpeed;
          end else begin
            ev = EvDropped;
          end
          rx_fill = 0;
          foreach (rx_buf[k]) rx_buf[k] = 8'h00;
        end
        r.tx_valid    = 1'b0;
        r.tx_byte     = 8'h00;
        r.last        = 1'b1;
        r.speed_left  = spd_l;
        r.speed_right = spd_r;
        r.rx_event    = ev;
        expected_out_q.push_back(r);
      end
      default: begin
        // The unused command leaves everything as it was.
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Idle length for the input side: mostly short, now and then long.
  function automatic int idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [15:0] rand_drive();
    int unsigned pick;
    int          v;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 16'($urandom);
    if (pick < 8) begin
      v = int'($urandom_range(0, 400)) - 200;
      return 16'(v);
    end
    if (pick == 8) return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    return 16'h0000;
  endfunction

  function automatic logic [14:0] rand_dead();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 15'($urandom_range(0, 2000));
    if (pick < 80) return 15'd0;
    if (pick < 90) return 15'h7FFF;
    return 15'($urandom);
  endfunction

  function automatic logic [14:0] rand_limit();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return 15'h7FFF;
    if (pick < 30) return 15'd0;
    if (pick < 70) return 15'($urandom_range(1, 20000));
    return 15'($urandom);
  endfunction

  function automatic logic [7:0] rand_non_sync();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == SyncByte) b = 8'h00;
    return b;
  endfunction

  // Receiver side: random stalls of the result channel.
  always @(posedge clk) begin : ready_drv
    int unsigned pick;
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        out_ready <= 1'b1;
        rdy_hold <= $urandom_range(0, 7);
      end else if (pick < 93) begin
        out_ready <= 1'b0;
        rdy_hold <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        rdy_hold <= $urandom_range(12, 35);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(negedge clk) begin : result_chk
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_out_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_item);
        mismatch_count++;
      end else begin
        exp_r = expected_out_q.pop_front();
        check_field("tx_valid", exp_r.tx_valid, out_item.tx_valid);
        check_field("tx_byte", exp_r.tx_byte, out_item.tx_byte);
        check_field("last", exp_r.last, out_item.last);
        check_field("speed_left", exp_r.speed_left, out_item.speed_left);
        check_field("speed_right", exp_r.speed_right, out_item.speed_right);
        check_field("rx_event", exp_r.rx_event, out_item.rx_event);
      end
    end
  end

  // Send one item; valid stays high on return so back-to-back items need no gap.
  task automatic send_item(in_item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(negedge clk); while (!in_ready);
    predict(it);
    if (it.cmd != CmdUnused) items_sent++;
    @(posedge clk);
  endtask

  task automatic send_drive(logic [15:0] lv, logic [15:0] rv);
    in_item_t it;
    it.cmd         = CmdDrive;
    it.drive_left  = lv;
    it.drive_right = rv;
    it.rx_byte     = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [7:0] b);
    in_item_t it;
    it.cmd         = cmd;
    it.drive_left  = rand_drive();
    it.drive_right = rand_drive();
    it.rx_byte     = b;
    send_item(it);
  endtask

  // Stop sending and wait until every expected result has come.
  task automatic wait_idle(int extra);
    in_valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write one register, then read it back.
  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {17'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      RegDeadLeft:   cfg_dead_l = val;
      RegDeadRight:  cfg_dead_r = val;
      RegDriveLimit: cfg_limit = val;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("prdata", val, rd[14:0]);
    @(posedge clk);
  endtask

  task automatic set_config(logic [14:0] dl, logic [14:0] dr, logic [14:0] lim);
    wait_idle(12);
    write_reg(RegDeadLeft, dl);
    write_reg(RegDeadRight, dr);
    write_reg(RegDriveLimit, lim);
  endtask

  // One received frame of the given kind, with a transmit item slipped in now and then.
  task automatic send_rx_frame(frame_kind_e kind);
    logic [7:0] frm [7];
    logic [7:0] sum;
    int         n;
    while (rx_fill != 0 && rx_buf[0] == SyncByte) send_cmd(CmdRx, rand_non_sync());
    frm[0] = SyncByte;
    frm[1] = FuncSpeed;
    for (int k = 2; k < 6; k++) frm[k] = 8'($urandom);
    n = 7;
    case (kind)
      FRM_BAD_FUNC: begin
        frm[1] = 8'($urandom);
        if (frm[1] == FuncSpeed) frm[1] = FuncDrive;
      end
      FRM_BAD_HEAD: frm[0] = rand_non_sync();
      FRM_SHORT:    n = $urandom_range(1, 6);
      default: ;
    endcase
    sum = '0;
    for (int k = 0; k < 6; k++) sum = sum + frm[k];
    frm[6] = sum;
    if (kind == FRM_BAD_SUM) frm[6] = sum ^ 8'($urandom_range(1, 255));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) send_drive(rand_drive(), rand_drive());
      send_cmd(CmdRx, frm[k]);
    end
  endtask

  // Drive extremes under the reset configuration, and the speed request.
  task automatic test_drive_reset_cfg();
    send_drive(16'h7FFF, 16'h7FFF);
    send_drive(16'h8000, 16'h8000);
    send_drive(16'h0000, 16'h0000);
    send_drive(16'h0001, 16'hFFFF);
    send_cmd(CmdSpeed, 8'($urandom));
  endtask

  task automatic test_unused_cmd();
    send_cmd(CmdUnused, 8'($urandom));
    send_cmd(CmdSpeed, 8'($urandom));
  endtask

  // A stray byte, then a sync byte that restarts collection of a good speed frame.
  task automatic test_rx_resync_frame();
    logic [6:0][7:0] frm;
    logic [7:0]      sum;
    frm = {8'h00, 8'h00, 8'h80, 8'h9C, 8'hFF, FuncSpeed, SyncByte};
    sum = '0;
    for (int k = 0; k < 6; k++) sum = sum + frm[k];
    frm[6] = sum;
    send_cmd(CmdRx, 8'h33);
    for (int k = 0; k < 7; k++) send_cmd(CmdRx, frm[k]);
  endtask

  // Dead-band and limit at their extremes.
  task automatic test_drive_extreme_cfg();
    set_config(15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_drive(16'h0001, 16'h0001);
    send_drive(16'hFFFF, 16'hFFFF);
    send_drive(16'h0000, 16'h0000);
    set_config(15'd0, 15'd0, 15'd0);
    send_drive(16'h0005, 16'hFFFB);
  endtask

  task automatic run_random_phase(int n, bit pause_mid);
    int          start;
    bit          paused;
    int unsigned pick;
    int unsigned sub;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < n) begin
      if (pause_mid && !paused && items_sent - start >= n / 2) begin
        wait_idle(1);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        sub = $urandom_range(0, 9);
        if (sub < 6) send_rx_frame(FRM_GOOD);
        else if (sub == 6) send_rx_frame(FRM_BAD_SUM);
        else if (sub == 7) send_rx_frame(FRM_BAD_FUNC);
        else if (sub == 8) send_rx_frame(FRM_BAD_HEAD);
        else send_rx_frame(FRM_SHORT);
      end else if (pick < 65) begin
        send_drive(rand_drive(), rand_drive());
      end else if (pick < 75) begin
        send_cmd(CmdSpeed, 8'($urandom));
      end else if (pick < 90) begin
        send_cmd(CmdRx, ($urandom_range(0, 2) == 0) ? SyncByte : 8'($urandom));
      end else begin
        send_cmd(CmdUnused, 8'($urandom));
      end
    end
  endtask

  task automatic test_random_phases();
    set_config(15'd0, 15'd0, 15'h7FFF);
    run_random_phase(26, 1'b0);
    set_config(rand_dead(), rand_dead(), rand_limit());
    run_random_phase(26, 1'b1);
    set_config(rand_dead(), rand_dead(), rand_limit());
    no_idle = 1'b1;
    run_random_phase(26, 1'b0);
    no_idle = 1'b0;
    set_config(15'h7FFF, 15'($urandom_range(0, 500)), rand_limit());
    run_random_phase(26, 1'b0);
    set_config(rand_dead(), rand_dead(), rand_limit());
    run_random_phase(26, 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_drive_reset_cfg();
    test_unused_cmd();
    test_rx_resync_frame();
    test_drive_extreme_cfg();
    test_random_phases();
    wait_idle(20);
    if (expected_out_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               expected_out_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
